// ===== hw/rtl/crc_sfh_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the split-frame header block.
package crc_sfh_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 24;
  localparam int unsigned CRC_W       = 32;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned HDR_FIFO_DEPTH = 2;

  // in_tdata field offsets
  localparam int unsigned BYTE_LSB  = 0;
  localparam int unsigned LEN_LSB   = 8;
  localparam int unsigned TOTAL_LSB = 32;
  localparam int unsigned INDEX_LSB = 40;

  // in_tuser bits
  localparam int unsigned USER_START = 0;
  localparam int unsigned USER_HAS   = 1;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [BYTE_W-1:0] HDR_MAGIC0 = 8'h1D;
  localparam logic [BYTE_W-1:0] HDR_MAGIC1 = 8'h76;
  localparam logic [BYTE_W-1:0] HDR_MAGIC2 = 8'h40;
  localparam logic [BYTE_W-1:0] HDR_MAGIC3 = 8'h42;

  // header byte offsets
  typedef enum logic [3:0] {
    HB_MAGIC0 = 4'd0,
    HB_MAGIC1 = 4'd1,
    HB_MAGIC2 = 4'd2,
    HB_MAGIC3 = 4'd3,
    HB_TOTAL  = 4'd4,
    HB_INDEX  = 4'd5,
    HB_LEN0   = 4'd6,
    HB_LEN1   = 4'd7,
    HB_LEN2   = 4'd8,
    HB_CRC0   = 4'd9,
    HB_CRC1   = 4'd10,
    HB_CRC2   = 4'd11,
    HB_CRC3   = 4'd12
  } hdr_pos_t;

  // one finished header, CRC already inverted
  typedef struct packed {
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] index_p1;
    logic [LEN_W-1:0]  length;
    logic [CRC_W-1:0]  crc;
  } hdr_info_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // reflected CRC-32, one byte, bitwise form unrolled by synthesis
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    x = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== hw/rtl/crc_sfh_core.sv =====
// Input register, frame state and CRC update; produces one header record per finished frame.
module crc_sfh_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [crc_sfh_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [crc_sfh_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  crc_sfh_pkg::fifo_stat_t               fifo_stat,
  output logic                                  hdr_push,
  output crc_sfh_pkg::hdr_info_t                hdr_info
);
  import crc_sfh_pkg::*;

  logic              cfg_covers_r;

  // input register
  logic              item_vld_r;
  logic              item_start_r;
  logic              item_has_r;
  logic [BYTE_W-1:0] item_byte_r;
  logic [LEN_W-1:0]  item_len_r;
  logic [BYTE_W-1:0] item_total_r;
  logic [BYTE_W-1:0] item_index_r;
  logic [CRC_W-1:0]  item_seed_r;
  logic [CRC_W-1:0]  seed_nxt;
  logic [LEN_W-1:0]  in_len;

  // frame state
  logic [CRC_W-1:0]  crc_r,      crc_nxt;
  logic [LEN_W-1:0]  seen_r,     seen_nxt;
  logic [LEN_W-1:0]  exp_r,      exp_nxt;
  logic [BYTE_W-1:0] total_r,    total_nxt;
  logic [BYTE_W-1:0] index_r,    index_nxt;
  logic              in_frame_r, in_frame_nxt;

  logic              empty_frame;
  logic              take_byte;
  logic              emit;
  logic              adv;
  logic              in_acc;
  logic [CRC_W-1:0]  crc_upd;

  assign in_len = in_tdata[LEN_LSB +: LEN_W];

  // length-byte seed computed on the way in, so the stage below does one byte
  always_comb begin
    seed_nxt = CRC_INIT;
    if (cfg_covers_r) begin
      seed_nxt = crc_byte(seed_nxt, in_len[7:0]);
      seed_nxt = crc_byte(seed_nxt, in_len[15:8]);
      seed_nxt = crc_byte(seed_nxt, in_len[23:16]);
    end
  end

  assign in_tready = !item_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_covers_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_covers_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_start_r <= in_tuser[USER_START];
      item_has_r   <= in_tuser[USER_HAS];
      item_byte_r  <= in_tdata[BYTE_LSB +: BYTE_W];
      item_len_r   <= in_len;
      item_total_r <= in_tdata[TOTAL_LSB +: BYTE_W];
      item_index_r <= in_tdata[INDEX_LSB +: BYTE_W];
      item_seed_r  <= seed_nxt;
    end
  end

  // a start restarts everything from the sampled fields
  always_comb begin
    crc_nxt      = item_start_r ? item_seed_r  : crc_r;
    seen_nxt     = item_start_r ? '0           : seen_r;
    exp_nxt      = item_start_r ? item_len_r   : exp_r;
    total_nxt    = item_start_r ? item_total_r : total_r;
    index_nxt    = item_start_r ? item_index_r : index_r;
    in_frame_nxt = item_start_r || in_frame_r;

    empty_frame = item_start_r && (item_len_r == '0);
    take_byte   = !empty_frame && item_has_r && in_frame_nxt;
    crc_upd     = crc_byte(crc_nxt, item_byte_r);
    emit        = empty_frame;

    if (take_byte) begin
      crc_nxt  = crc_upd;
      seen_nxt = seen_nxt + LEN_W'(1);
      if (seen_nxt == exp_nxt) begin
        emit = 1'b1;
      end
    end
    if (emit) begin
      in_frame_nxt = 1'b0;
    end
  end

  // hold the item while a header has nowhere to go
  assign adv      = item_vld_r && !(emit && fifo_stat.full);
  assign hdr_push = adv && emit;

  assign hdr_info.total    = total_nxt;
  assign hdr_info.index_p1 = index_nxt + BYTE_W'(1);
  assign hdr_info.length   = exp_nxt;
  assign hdr_info.crc      = ~crc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      seen_r     <= '0;
      exp_r      <= '0;
      total_r    <= '0;
      index_r    <= '0;
      in_frame_r <= 1'b0;
    end else if (adv) begin
      crc_r      <= crc_nxt;
      seen_r     <= seen_nxt;
      exp_r      <= exp_nxt;
      total_r    <= total_nxt;
      index_r    <= index_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

// ===== hw/rtl/crc_sfh_fifo.sv =====
// Small queue of finished header records between the frame core and the byte serializer.
module crc_sfh_fifo #(
  parameter int unsigned DEPTH = crc_sfh_pkg::HDR_FIFO_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  crc_sfh_pkg::hdr_info_t  push_info,
  input  logic                    pop,
  output crc_sfh_pkg::hdr_info_t  head_info,
  output crc_sfh_pkg::fifo_stat_t stat
);
  import crc_sfh_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hdr_info_t         entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_info  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_info;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/crc_sfh_ser.sv =====
// Header serializer: walks the 13 header bytes of the queue head into the output register.
module crc_sfh_ser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  crc_sfh_pkg::fifo_stat_t          fifo_stat,
  input  crc_sfh_pkg::hdr_info_t           head_info,
  output logic                             hdr_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [crc_sfh_pkg::BYTE_W-1:0]   out_tdata,
  output logic                             out_tlast
);
  import crc_sfh_pkg::*;

  hdr_pos_t          pos_r, pos_nxt;
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_data_r, byte_nxt;
  logic              out_last_r;
  logic              load;
  logic              at_end;

  assign load   = !fifo_stat.empty && (!out_vld_r || out_tready);
  assign at_end = (pos_r == HB_CRC3);
  assign hdr_pop = load && at_end;

  always_comb begin
    case (pos_r)
      HB_MAGIC0: byte_nxt = HDR_MAGIC0;
      HB_MAGIC1: byte_nxt = HDR_MAGIC1;
      HB_MAGIC2: byte_nxt = HDR_MAGIC2;
      HB_MAGIC3: byte_nxt = HDR_MAGIC3;
      HB_TOTAL:  byte_nxt = head_info.total;
      HB_INDEX:  byte_nxt = head_info.index_p1;
      HB_LEN0:   byte_nxt = head_info.length[7:0];
      HB_LEN1:   byte_nxt = head_info.length[15:8];
      HB_LEN2:   byte_nxt = head_info.length[23:16];
      HB_CRC0:   byte_nxt = head_info.crc[7:0];
      HB_CRC1:   byte_nxt = head_info.crc[15:8];
      HB_CRC2:   byte_nxt = head_info.crc[23:16];
      HB_CRC3:   byte_nxt = head_info.crc[31:24];
      default:   byte_nxt = '0;
    endcase
    pos_nxt = at_end ? HB_MAGIC0 : hdr_pos_t'(pos_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= HB_MAGIC0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        pos_r     <= pos_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= byte_nxt;
      out_last_r <= at_end;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/crc32_split_frame_header.sv =====
// First header byte path: input register, header queue, then the output register on out_tvalid.
// Throughput, unless stalled: one input transaction and one header byte per cycle.
// Input stalls only when a header is ready and the header queue (HDR_FIFO_DEPTH records) is full.
// The CRC path is one byte-wide unrolled update per cycle; length seed is done at input capture.
// Reset (rst_n low, synchronous) clears CRC to all ones, counters and mode to zero, queue empty.
module crc32_split_frame_header #(
  parameter int unsigned HDR_FIFO_DEPTH = crc_sfh_pkg::HDR_FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration: crc_covers_length
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  // payload stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] byte_value, [31:8] payload_length, [39:32] part_total, [47:40] part_index
  input  logic [crc_sfh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] frame_start, [1] has_byte
  input  logic [crc_sfh_pkg::IN_TUSER_W-1:0]  in_tuser,
  // header stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] header_byte
  output logic [crc_sfh_pkg::BYTE_W-1:0]      out_tdata,
  // header_last: set on the final CRC byte
  output logic                                out_tlast
);
  import crc_sfh_pkg::*;

  fifo_stat_t fifo_stat;
  hdr_info_t  push_info;
  hdr_info_t  head_info;
  logic       hdr_push;
  logic       hdr_pop;

  // Frame core: registers each input transaction, then runs the frame state
  // and one CRC byte update; a finished frame becomes one header record.
  crc_sfh_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .fifo_stat   (fifo_stat),
    .hdr_push    (hdr_push),
    .hdr_info    (push_info)
  );

  // Header records wait here while earlier headers drain byte by byte.
  crc_sfh_fifo #(
    .DEPTH (HDR_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (hdr_push),
    .push_info (push_info),
    .pop       (hdr_pop),
    .head_info (head_info),
    .stat      (fifo_stat)
  );

  // Serializer with output register; pops a record as its last byte loads.
  crc_sfh_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .head_info  (head_info),
    .hdr_pop    (hdr_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // core must never push into a full header queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(hdr_push && fifo_stat.full))
    else $error("header queue overflow");

  // serializer pops only a record that exists
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pop |-> !fifo_stat.empty)
    else $error("header queue underflow");

  // popping a record means its last byte is on the output next cycle
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pop |=> (out_tvalid && out_tlast))
    else $error("header pop without last byte");

endmodule

// ===== sim/tb_crc32_split_frame_header.sv =====
// Self-checking testbench for the split-frame header builder with reflected CRC-32.
module tb_crc32_split_frame_header;
  timeunit 1ns;
  timeprecision 1ps;

  import crc_sfh_pkg::*;

  // ---------------------------------------------------------------------------
  // Run parameters
  // ---------------------------------------------------------------------------
  localparam int unsigned POST_LAT    = 6;        // cycles after last header byte
  localparam int unsigned HOLD_CYCLES = 300;      // long receiver hold-off
  localparam int unsigned PHASE_ITEMS = 70;       // counted start/byte transactions per phase
  localparam int unsigned BURST_ITEMS = 30;       // short frames under hold-off
  localparam realtime     TIMEOUT_NS  = 3_000_000;

  // one input transaction, fields as in_tdata / in_tuser carry them
  typedef struct packed {
    logic              start;
    logic              has;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] idx;
  } seg_item_t;

  // one header byte as it should leave the block
  typedef struct packed {
    logic [BYTE_W-1:0] hbyte;
    logic              last;
  } hdr_beat_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // directed row: a transaction or a mode write; typed rows carry the header's
  // index byte and CRC as read straight off the spec (empty frames, no seed)
  typedef struct packed {
    row_kind_t         kind;
    logic              cfg_val;
    logic              start;
    logic              has;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] idx;
    logic              typed;
    logic [BYTE_W-1:0] t_idx1;
    logic [CRC_W-1:0]  t_crc;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 24;

  // kind, cfg, start, has, byte, length, total, index, typed, index+1, crc
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty frame right after reset, all fields zero: header with CRC 0
    '{ROW_ITEM, 1'b0, 1'b1, 1'b0, 8'h00, 24'h000000, 8'h00, 8'h00, 1'b1, 8'h01, 32'h0},
    // empty frame at field maxima, index wraps to 0, its byte is dropped
    '{ROW_ITEM, 1'b0, 1'b1, 1'b1, 8'hFF, 24'h000000, 8'hFF, 8'hFF, 1'b1, 8'h00, 32'h0},
    // byte while no frame is open: ignored
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'hA5, 24'h123456, 8'h12, 8'h34, 1'b0, 8'h00, 32'h0},
    // neither start nor byte
    '{ROW_ITEM, 1'b0, 1'b0, 1'b0, 8'h00, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    // one-byte frame closed on its own start transaction
    '{ROW_ITEM, 1'b0, 1'b1, 1'b1, 8'h00, 24'h000001, 8'h01, 8'h00, 1'b0, 8'h00, 32'h0},
    // start without a byte, then three bytes
    '{ROW_ITEM, 1'b0, 1'b1, 1'b0, 8'h00, 24'h000003, 8'h03, 8'h01, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'hFF, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'h00, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'h5A, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    // unfinished frame abandoned by a start that carries a byte
    '{ROW_ITEM, 1'b0, 1'b1, 1'b0, 8'h00, 24'h000004, 8'h02, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'h11, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b1, 1'b1, 8'h22, 24'h000002, 8'h02, 8'h01, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b0, 8'h00, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'h33, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    // maximum length, cut short by an empty frame
    '{ROW_ITEM, 1'b0, 1'b1, 1'b0, 8'h00, 24'hFFFFFF, 8'hFF, 8'hFE, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'h80, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b1, 1'b0, 8'h00, 24'h000000, 8'h01, 8'h7F, 1'b1, 8'h80, 32'h0},
    // CRC seeded with the length bytes from here on
    '{ROW_CFG,  1'b1, 1'b0, 1'b0, 8'h00, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b1, 1'b0, 8'h00, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b1, 1'b1, 8'hFF, 24'h000002, 8'hAA, 8'h55, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b0, 1'b1, 8'h01, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b1, 1'b1, 8'hC3, 24'h800001, 8'h10, 8'h20, 1'b0, 8'h00, 32'h0},
    '{ROW_ITEM, 1'b0, 1'b1, 1'b1, 8'h7E, 24'h000001, 8'hFF, 8'h00, 1'b0, 8'h00, 32'h0},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, 8'h00, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0}
  };

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata    = '0;
  logic [IN_TUSER_W-1:0] in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tlast;

  crc32_split_frame_header u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the frame tracker and the mode register
  // ---------------------------------------------------------------------------
  logic [CRC_W-1:0]  pf_crc   = CRC_INIT;
  logic [LEN_W-1:0]  pf_count = '0;
  logic [LEN_W-1:0]  pf_len   = '0;
  logic [BYTE_W-1:0] pf_total = '0;
  logic [BYTE_W-1:0] pf_idx   = '0;
  logic              pf_open  = 1'b0;
  logic              pf_cover = 1'b0;   // crc_covers_length shadow

  hdr_beat_t hdr_expect_q [$];
  hdr_beat_t rx_want;

  // traffic knobs, read by the driver processes
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_asked  = 0;   // bumped by the stimulus to request a hold-off
  int unsigned hold_served = 0;   // bumped by the receiver when one is done

  // bookkeeping
  int unsigned mism_cnt       = 0;
  int unsigned items_used     = 0;
  int unsigned frames_closed  = 0;
  int unsigned frames_dropped = 0;
  int unsigned hdr_checked    = 0;

  // bit-serial reflected CRC-32: each data bit is folded in at the LSB
  function automatic logic [CRC_W-1:0] crc32_fold_byte(input logic [CRC_W-1:0] acc,
                                                       input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = acc;
    for (int i = 0; i < BYTE_W; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : '0);
    end
    return r;
  endfunction

  // lay out the 13 header bytes in wire order
  function automatic void queue_header(input logic [BYTE_W-1:0] tot,
                                       input logic [BYTE_W-1:0] idx1,
                                       input logic [LEN_W-1:0]  len,
                                       input logic [CRC_W-1:0]  crc);
    hdr_beat_t b;
    hdr_pos_t  pos;
    for (int k = 0; k <= int'(HB_CRC3); k++) begin
      pos = hdr_pos_t'(k);
      case (pos)
        HB_MAGIC0: b.hbyte = HDR_MAGIC0;
        HB_MAGIC1: b.hbyte = HDR_MAGIC1;
        HB_MAGIC2: b.hbyte = HDR_MAGIC2;
        HB_MAGIC3: b.hbyte = HDR_MAGIC3;
        HB_TOTAL:  b.hbyte = tot;
        HB_INDEX:  b.hbyte = idx1;
        HB_LEN0:   b.hbyte = len[7:0];
        HB_LEN1:   b.hbyte = len[15:8];
        HB_LEN2:   b.hbyte = len[23:16];
        HB_CRC0:   b.hbyte = crc[7:0];
        HB_CRC1:   b.hbyte = crc[15:8];
        HB_CRC2:   b.hbyte = crc[23:16];
        HB_CRC3:   b.hbyte = crc[31:24];
        default:   b.hbyte = '0;
      endcase
      b.last = (pos == HB_CRC3);
      hdr_expect_q.push_back(b);
    end
  endfunction

  // advance the shadow tracker by one accepted transaction; quiet leaves the
  // header to the caller (directed rows with typed results)
  function automatic void predict_header(input seg_item_t it, input bit quiet);
    bit close;
    close = 1'b0;
    if (it.start || (it.has && pf_open))
      items_used++;
    if (it.start) begin
      if (pf_open)
        frames_dropped++;
      pf_len   = it.len;
      pf_total = it.total;
      pf_idx   = it.idx;
      pf_count = '0;
      pf_crc   = CRC_INIT;
      // optional seed: the three length bytes, low byte first
      if (pf_cover) begin
        for (int s = 0; s < 3; s++)
          pf_crc = crc32_fold_byte(pf_crc, pf_len[8*s +: 8]);
      end
      pf_open = 1'b1;
      if (pf_len == '0)
        close = 1'b1;   // empty frame: header now, byte dropped
    end
    if (!close && it.has && pf_open) begin
      pf_crc   = crc32_fold_byte(pf_crc, it.data);
      pf_count = pf_count + 1'b1;
      if (pf_count == pf_len)
        close = 1'b1;
    end
    if (close) begin
      pf_open = 1'b0;
      frames_closed++;
      if (!quiet)
        queue_header(pf_total, pf_idx + 8'd1, pf_len, ~pf_crc);
    end
  endfunction

  function automatic seg_item_t rand_item();
    seg_item_t r;
    r.start = 1'($urandom_range(1));
    r.has   = 1'($urandom_range(1));
    r.data  = 8'($urandom);
    r.len   = 24'($urandom);
    r.total = 8'($urandom);
    r.idx   = 8'($urandom);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: random idle gaps, then hold the transaction until accepted
  // ---------------------------------------------------------------------------
  task automatic send_item(input seg_item_t it, input bit typed = 1'b0,
                           input logic [BYTE_W-1:0] t_idx1 = '0,
                           input logic [CRC_W-1:0] t_crc = '0);
    logic [IN_TDATA_W-1:0] td;
    logic [IN_TUSER_W-1:0] tu;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    td = '0;
    td[BYTE_LSB  +: BYTE_W] = it.data;
    td[LEN_LSB   +: LEN_W]  = it.len;
    td[TOTAL_LSB +: BYTE_W] = it.total;
    td[INDEX_LSB +: BYTE_W] = it.idx;
    tu = '0;
    tu[USER_START] = it.start;
    tu[USER_HAS]   = it.has;
    in_tvalid <= 1'b1;
    in_tdata  <= td;
    in_tuser  <= tu;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    // transaction taken at this edge
    predict_header(it, typed);
    if (typed)
      queue_header(it.total, t_idx1, it.len, t_crc);
  endtask

  // stop offering and wait until every predicted header byte is out, plus
  // a few cycles for transactions that produce no header
  task automatic drain_headers();
    in_tvalid <= 1'b0;
    while (hdr_expect_q.size() != 0)
      @(posedge clk);
    repeat (POST_LAT) @(posedge clk);
  endtask

  // mode write, only with the block quiet
  task automatic write_cover(input logic v);
    drain_headers();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    pf_cover   = v;
    cfg_wr_en <= 1'b0;
  endtask

  // one random chunk: mostly whole frames, some cut-off frames, some noise
  task automatic send_random_burst();
    seg_item_t   it;
    int unsigned sel;
    int unsigned left;
    sel = $urandom_range(99);
    it  = rand_item();
    if (sel < 70) begin
      // well-formed frame, mostly short, bytes sprinkled with empty transactions
      it.start = 1'b1;
      it.len   = ($urandom_range(9) == 0) ? 24'($urandom_range(40, 13))
                                          : 24'($urandom_range(12, 0));
      send_item(it);
      left = it.len;
      if (it.has && left != 0)
        left--;
      while (left != 0) begin
        it       = rand_item();
        it.start = 1'b0;
        it.has   = ($urandom_range(9) != 0);
        if (it.has)
          left--;
        send_item(it);
      end
    end else if (sel < 85) begin
      // start with a full-range length, a few bytes, then left to be cut off
      it.start = 1'b1;
      send_item(it);
      repeat ($urandom_range(4)) begin
        it       = rand_item();
        it.start = 1'b0;
        it.has   = 1'b1;
        send_item(it);
      end
    end else begin
      // stray transaction without a start
      it.start = 1'b0;
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready driver with random stalls and on-request hold-off
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end
      out_tready <= !rst_n ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end
  end

  // header checker: every accepted byte against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hdr_expect_q.size() == 0) begin
        $error("header byte 0x%02h (last=%0b) arrived with nothing expected",
               out_tdata, out_tlast);
        mism_cnt++;
      end else begin
        rx_want = hdr_expect_q.pop_front();
        if (out_tdata !== rx_want.hbyte) begin
          $error("header_byte: expected 0x%02h, got 0x%02h", rx_want.hbyte, out_tdata);
          mism_cnt++;
        end
        if (out_tlast !== rx_want.last) begin
          $error("header_last: expected %0b, got %0b", rx_want.last, out_tlast);
          mism_cnt++;
        end
        hdr_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    seg_item_t   it;
    int unsigned target;
    int unsigned idle_tab  [4];
    int unsigned stall_tab [4];
    logic        mode_tab  [4];

    idle_tab  = '{0, 73, 0, 9};
    stall_tab = '{0, 0, 73, 9};
    mode_tab  = '{1'b1, 1'b0, 1'b1, 1'b0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling on either side
    foreach (DIR_TAB[r]) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        write_cover(DIR_TAB[r].cfg_val);
      end else begin
        it.start = DIR_TAB[r].start;
        it.has   = DIR_TAB[r].has;
        it.data  = DIR_TAB[r].data;
        it.len   = DIR_TAB[r].len;
        it.total = DIR_TAB[r].total;
        it.idx   = DIR_TAB[r].idx;
        send_item(it, DIR_TAB[r].typed, DIR_TAB[r].t_idx1, DIR_TAB[r].t_crc);
      end
    end

    // random phases: free flow, sender gaps, receiver stalls, light both,
    // alternating the CRC mode at each phase boundary
    target = items_used;
    for (int p = 0; p < 4; p++) begin
      write_cover(mode_tab[p]);
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      target += PHASE_ITEMS;
      while (items_used < target)
        send_random_burst();
    end

    // back-pressure: receiver holds off while short frames keep coming, so the
    // header queue fills and the input stalls; then pause until all is out
    write_cover(1'b1);
    idle_pct  = 0;
    stall_pct = 0;
    hold_asked++;
    repeat (BURST_ITEMS) begin
      it       = rand_item();
      it.start = 1'b1;
      it.has   = 1'b1;
      it.len   = 24'($urandom_range(1));
      send_item(it);
    end
    drain_headers();

    $display("Covered %0d closed and %0d abandoned frames over %0d start/byte transactions,",
             frames_closed, frames_dropped, items_used);
    $display("%0d header bytes checked with and without the length seed, under stalls.",
             hdr_checked);
    if (mism_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d header bytes still expected", hdr_expect_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
